/* sv/lkvc_pkg.sv */
// Shared types and constants for the LRU key-value cache.
`timescale 1ns / 1ps

package lkvc_pkg;

	// Number of entries in the fully associative array.
	localparam int MaxEntries = 16;
	// Entry index and recency rank width.
	localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
	// Width of an entry count, which can reach MaxEntries itself.
	localparam int CntW = $clog2(MaxEntries + 1);
	// Field widths fixed by the interface.
	localparam int CapW = 5;
	localparam int KeyW = 32;
	localparam int ValW = 32;
	// Common width for count and capacity compares; holds MaxEntries + 1 while MaxEntries < 255.
	localparam int CmpW = 8;

	localparam logic [CapW-1:0] CapReset = CapW'(16);
	localparam logic [ValW-1:0] MissValue = '1;

	typedef enum logic {
		OpGet = 1'b0,
		OpPut = 1'b1
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [KeyW-1:0] key;
		logic [ValW-1:0] value;
	} req_t;

	typedef struct packed {
		logic            hit;
		logic [ValW-1:0] read_value;
		logic            evicted;
	} rsp_t;

	typedef struct packed {
		logic [CntW-1:0] count;
		logic            full;
	} stat_t;

endpackage

/* sv/lkvc_in_stage.sv */
// Input register stage: captures one request beat from the slave stream.
`timescale 1ns / 1ps

module lkvc_in_stage import lkvc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
	input  logic        s_tuser,   // [0] op
	input  logic        take,
	output logic        valid_s1,
	output req_t        req_s1
);

	// The stage frees up in the same cycle its content moves on.
	assign s_tready = !valid_s1 || take;

	// Occupancy of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Request payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.op    <= op_t'(s_tuser);
			req_s1.key   <= s_tdata[KeyW-1:0];
			req_s1.value <= s_tdata[KeyW+ValW-1:KeyW];
		end
	end

endmodule

/* sv/lkvc_store.sv */
// Entry array with parallel key match, recency ranks and LRU replacement.
`timescale 1ns / 1ps

module lkvc_store import lkvc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_fire,
	input  req_t            req,
	input  logic [CapW-1:0] capacity,
	output rsp_t            rsp,
	output stat_t           stat
);

	logic [KeyW-1:0]       key_q   [MaxEntries];
	logic [ValW-1:0]       value_q [MaxEntries];
	logic [IdxW-1:0]       rank_q  [MaxEntries];
	logic [MaxEntries-1:0] valid_q;

	logic [MaxEntries-1:0] match;
	logic [MaxEntries-1:0] free_low;
	logic [MaxEntries-1:0] victim;
	logic [MaxEntries-1:0] slot_oh;
	logic                  hit_any;
	logic [IdxW-1:0]       hit_rank;
	logic [ValW-1:0]       hit_val;
	logic [CntW-1:0]       count;
	logic [CntW-1:0]       count_m1;
	logic [IdxW-1:0]       last_rank;
	logic                  full;
	logic [CmpW-1:0]       cap_ext;
	logic [CmpW-1:0]       cap_sat;
	logic                  over_cap;
	logic                  new_put;
	logic                  evict_old;
	logic                  drop_new;

	// Parallel key compare; keys are unique among valid entries, so match is one-hot.
	always_comb begin
		hit_rank = '0;
		hit_val  = '0;
		for (int i = 0; i < MaxEntries; i++) begin
			match[i] = valid_q[i] && (key_q[i] == req.key);
			if (match[i]) begin
				hit_rank = hit_rank | rank_q[i];
				hit_val  = hit_val | value_q[i];
			end
		end
		hit_any = |match;
	end

	// Occupancy and the lowest numbered free entry.
	assign count    = CntW'($countones(valid_q));
	assign full     = (count == CntW'(MaxEntries));
	assign free_low = ~valid_q & (valid_q + MaxEntries'(1));

	// The least recent entry holds the highest rank, which is count - 1.
	assign count_m1  = count - CntW'(1);
	assign last_rank = count_m1[IdxW-1:0];
	always_comb begin
		for (int i = 0; i < MaxEntries; i++) begin
			victim[i] = valid_q[i] && (rank_q[i] == last_rank);
		end
	end

	// Capacity check, with the register saturated at the array depth.
	assign cap_ext  = CmpW'(capacity);
	assign cap_sat  = (cap_ext > CmpW'(MaxEntries)) ? CmpW'(MaxEntries) : cap_ext;
	assign over_cap = (CmpW'(count) + CmpW'(1)) > cap_sat;

	// Insertion control. With the array full the victim's entry takes the new key.
	// With an empty array and no room, the new key itself is the one dropped.
	assign new_put   = (req.op == OpPut) && !hit_any;
	assign evict_old = new_put && (full || (over_cap && (count != '0)));
	assign drop_new  = new_put && !full && over_cap && (count == '0);
	assign slot_oh   = full ? victim : free_low;

	// Result of this item.
	always_comb begin
		rsp.hit        = hit_any;
		rsp.evicted    = new_put && (full || over_cap);
		rsp.read_value = '0;
		if (req.op == OpGet) begin
			rsp.read_value = hit_any ? hit_val : MissValue;
		end
	end

	assign stat.count = count;
	assign stat.full  = full;

	// Valid bits: set on insertion, cleared on eviction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req_fire && new_put) begin
			for (int i = 0; i < MaxEntries; i++) begin
				if (slot_oh[i]) begin
					valid_q[i] <= !drop_new;
				end else if (evict_old && victim[i]) begin
					valid_q[i] <= 1'b0;
				end
			end
		end
	end

	// Keys, values and recency ranks.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			for (int i = 0; i < MaxEntries; i++) begin
				if (hit_any) begin
					// Touched entry becomes most recent; more recent ones age by one.
					if (match[i]) begin
						rank_q[i] <= '0;
						if (req.op == OpPut) begin
							value_q[i] <= req.value;
						end
					end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_q[i] <= rank_q[i] + IdxW'(1);
					end
				end else if (new_put) begin
					// New key enters as most recent; every other entry ages by one.
					if (slot_oh[i]) begin
						key_q[i]   <= req.key;
						value_q[i] <= req.value;
						rank_q[i]  <= '0;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + IdxW'(1);
					end
				end
			end
		end
	end

endmodule

/* sv/lkvc_out_stage.sv */
// Result register: holds one response beat for the master stream.
`timescale 1ns / 1ps

module lkvc_out_stage import lkvc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  rsp_t        rsp,
	output logic        space,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] read_value
	output logic [1:0]  m_tuser    // [0] hit, [1] evicted
);

	rsp_t rsp_s2;

	// A new result may enter when the register is empty or being drained.
	assign space = !m_tvalid || m_tready;

	// Occupancy of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (space) begin
			m_tvalid <= load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_s2 <= rsp;
		end
	end

	assign m_tdata    = rsp_s2.read_value;
	assign m_tuser[0] = rsp_s2.hit;
	assign m_tuser[1] = rsp_s2.evicted;

endmodule

/* sv/lru_key_value_cache.sv */
// Top level of the fully associative LRU key-value cache.
//
//   Channel  Direction  Signals                      Beat contents
//   s_*      in         s_tvalid/s_tready            tdata: key, value; tuser: op
//   m_*      out        m_tvalid/m_tready            tdata: read_value; tuser: hit, evicted
//   cfg_*    in         cfg_valid/cfg_ready          cfg_data: capacity_in_use
//
// One item per cycle sustained while the master is ready; a request beat is held in
// the input register and its result in the result register. The whole lookup, rank
// update and replacement for an item is combinational, against the 16-entry array.
// Reset clears all valid bits at once and sets the capacity to 16; no clearing pass.
// A stalled master holds the result register; one more request still enters the
// input register before the slave side stalls.
`timescale 1ns / 1ps

module lru_key_value_cache import lkvc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
	input  logic        s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] read_value
	output logic [1:0]  m_tuser,   // [0] hit, [1] evicted
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data   // [4:0] capacity_in_use
);

	logic            valid_s1;
	req_t            req_s1;
	rsp_t            rsp;
	stat_t           stat;
	logic            out_space;
	logic            adv;
	logic [CapW-1:0] capacity_q;

	// Capacity register; the user must write it only while the cache is idle; the block does not enforce it.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CapReset;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// An item is processed when it sits in the input register and the result can go out.
	assign adv = valid_s1 && out_space;

	lkvc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.take     (adv),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	lkvc_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_fire (adv),
		.req      (req_s1),
		.capacity (capacity_q),
		.rsp      (rsp),
		.stat     (stat)
	);

	lkvc_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.rsp      (rsp),
		.space    (out_space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

`ifndef SYNTH
	// Only a put of a new key can evict, so an evicting result never reports a hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0])
		else $error("eviction reported together with a hit");

	// A get never changes how many entries are held.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && (req_s1.op == OpGet) |=> stat.count == $past(stat.count))
		else $error("get changed the entry count");

	// An evicting put never grows the entry count.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && rsp.evicted |=> stat.count <= $past(stat.count))
		else $error("evicting put grew the entry count");

	// A put of a new key without eviction adds exactly one entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && (req_s1.op == OpPut) && !rsp.hit && !rsp.evicted
		|=> stat.count == $past(stat.count) + CntW'(1))
		else $error("insertion did not add one entry");
`endif

endmodule
